FILE: sv/g2e_pkg.sv
// g2e_pkg: shared types, constants and table functions for the Gregorian
// date to elapsed time block. No dependencies.
package g2e_pkg;

    // Field widths of the stream payloads
    localparam int unsigned MONTH_W   = 4;
    localparam int unsigned DAY_W     = 5;
    localparam int unsigned HOUR_W    = 5;
    localparam int unsigned MINUTE_W  = 6;
    localparam int unsigned SEC_US_W  = 26;
    localparam int unsigned FIELD_YEAR_W = 12;
    localparam int unsigned ELAPSED_W = 57;
    localparam int unsigned DAYS_W    = 21;
    localparam int unsigned MINS_W    = 32;
    localparam int unsigned PROD_W    = MINS_W + SEC_US_W;
    localparam int unsigned DOY_W     = 9;
    localparam int unsigned LEAPS_W   = 11;

    // Year arithmetic runs on 13 bits: covers year + 399 for a 12-bit year
    localparam int unsigned YSUM_W    = 13;
    localparam int unsigned Q100_W    = 7;
    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x < 2**13
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int unsigned RECIP_SHIFT = 19;

    localparam logic [11:0] BASE_YEAR_RST = 12'd1970;
    localparam logic [10:0] MIN_PER_DAY   = 11'd1440;
    localparam logic [5:0]  MIN_PER_HOUR  = 6'd60;
    localparam logic [25:0] US_PER_MIN    = 26'd60000000;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;

    localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEAP,
        ST_DAYS,
        ST_MIN,
        ST_US,
        ST_DONE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic step_leap;
        logic step_days;
        logic step_min;
        logic step_us;
        logic load_out;
    } cmd_t;

    // floor(x / 100) by reciprocal multiply
    function automatic logic [Q100_W-1:0] div100(input logic [YSUM_W-1:0] x);
        logic [2*YSUM_W-1:0] prod;
        prod = x * RECIP_100;
        return Q100_W'(prod >> RECIP_SHIFT);
    endfunction

    // Days before the first of a month; idx is month - 1
    function automatic logic [DOY_W-1:0] days_before(input logic leap,
                                                     input logic [MONTH_W-1:0] idx);
        logic [DOY_W-1:0] d;
        case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        // Leap years gain a day from March on
        if (leap && (idx >= 4'd2) && (idx <= 4'd11)) begin
            d = d + 9'd1;
        end
        return d;
    endfunction

endpackage

FILE: sv/g2e_ctrl.sv
// g2e_ctrl: sequencing state machine and output handshake for the
// date conversion. Depends on g2e_pkg.
module g2e_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output g2e_pkg::cmd_t   cmd
);

    g2e_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    // Output register can take a result this cycle
    assign out_free = !out_valid_reg || m_tready;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= g2e_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            g2e_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = g2e_pkg::ST_LEAP;
            end
            g2e_pkg::ST_LEAP: state_next = g2e_pkg::ST_DAYS;
            g2e_pkg::ST_DAYS: state_next = g2e_pkg::ST_MIN;
            g2e_pkg::ST_MIN:  state_next = g2e_pkg::ST_US;
            g2e_pkg::ST_US:   state_next = g2e_pkg::ST_DONE;
            g2e_pkg::ST_DONE: begin
                if (out_free) state_next = g2e_pkg::ST_IDLE;
            end
            default: state_next = g2e_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        cmd            = '0;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            g2e_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            g2e_pkg::ST_LEAP: cmd.step_leap = 1'b1;
            g2e_pkg::ST_DAYS: cmd.step_days = 1'b1;
            g2e_pkg::ST_MIN:  cmd.step_min  = 1'b1;
            g2e_pkg::ST_US:   cmd.step_us   = 1'b1;
            g2e_pkg::ST_DONE: begin
                cmd.load_out = out_free;
                if (out_free) out_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;

    // Accepted request starts the leap-count step
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == g2e_pkg::ST_LEAP))
        else $error("accepted request did not start processing");

    // A loaded result is presented on the next cycle
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_tvalid)
        else $error("loaded result not presented");

    // Output never overwritten while a result is held back
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !cmd.load_out)
        else $error("pending result overwritten");

    // Result valid only rises after the final step
    a_rise_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(state_reg) == g2e_pkg::ST_DONE))
        else $error("result valid without finished computation");

endmodule

FILE: sv/g2e_dp.sv
// g2e_dp: datapath registers and arithmetic for the date conversion,
// stepped by g2e_ctrl commands. Depends on g2e_pkg.
module g2e_dp #(
    parameter int unsigned YEAR_WIDTH = 12
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  g2e_pkg::cmd_t                         cmd,
    input  logic                                  cfg_we,
    input  logic [g2e_pkg::FIELD_YEAR_W-1:0]      cfg_wdata,
    input  logic [g2e_pkg::FIELD_YEAR_W-1:0]      in_year,
    input  logic [g2e_pkg::MONTH_W-1:0]           in_month,
    input  logic [g2e_pkg::DAY_W-1:0]             in_day,
    input  logic [g2e_pkg::HOUR_W-1:0]            in_hour,
    input  logic [g2e_pkg::MINUTE_W-1:0]          in_minute,
    input  logic [g2e_pkg::SEC_US_W-1:0]          in_second_us,
    output logic [g2e_pkg::ELAPSED_W-1:0]         out_elapsed_us,
    output logic [g2e_pkg::DAYS_W-1:0]            out_day_count,
    output logic                                  out_bad_input
);

    // Effective year width: the year field carries 12 bits at most
    localparam int unsigned YW = (YEAR_WIDTH < g2e_pkg::FIELD_YEAR_W) ?
                                 YEAR_WIDTH : g2e_pkg::FIELD_YEAR_W;
    localparam int unsigned SW = g2e_pkg::YSUM_W;

    logic [g2e_pkg::FIELD_YEAR_W-1:0] base_year_reg;
    logic [YW-1:0]                    year_reg;
    logic [g2e_pkg::MONTH_W-1:0]      month_reg;
    logic [g2e_pkg::DAY_W-1:0]        day_reg;
    logic [g2e_pkg::HOUR_W-1:0]       hour_reg;
    logic [g2e_pkg::MINUTE_W-1:0]     minute_reg;
    logic [g2e_pkg::SEC_US_W-1:0]     sec_us_reg;
    logic                             bad_reg;
    logic [g2e_pkg::LEAPS_W-1:0]      leaps_y_reg, leaps_b_reg;
    logic                             leap_reg;
    logic [g2e_pkg::DAYS_W-1:0]       days_reg;
    logic [g2e_pkg::MINS_W-1:0]       mins_reg;
    logic [g2e_pkg::ELAPSED_W-1:0]    prod_reg;
    logic [g2e_pkg::ELAPSED_W-1:0]    elapsed_reg;
    logic [g2e_pkg::DAYS_W-1:0]       day_cnt_reg;
    logic                             bad_out_reg;

    logic [YW-1:0]                    base_eff;
    logic [g2e_pkg::LEAPS_W-1:0]      leaps_y_next, leaps_b_next;
    logic                             leap_next;
    logic [g2e_pkg::Q100_W-1:0]       qy;
    logic [g2e_pkg::YSUM_W-1:0]       rem_y;
    logic [g2e_pkg::DAYS_W-1:0]       year_days;
    logic [g2e_pkg::DAYS_W-1:0]       days_next;
    logic [g2e_pkg::MINS_W-1:0]       mins_next;
    logic [g2e_pkg::MONTH_W-1:0]      month_idx;
    logic                             bad_next;

    // Leap years in [0, n - 1], year 0 counted as leap
    function automatic logic [g2e_pkg::LEAPS_W-1:0] leaps_below(input logic [YW-1:0] n);
        logic [SW-1:0] n3, n99, n399;
        logic [g2e_pkg::Q100_W-1:0] q99, q399;
        n3   = SW'(n) + SW'(3);
        n99  = SW'(n) + SW'(99);
        n399 = SW'(n) + SW'(399);
        q99  = g2e_pkg::div100(n99);
        q399 = g2e_pkg::div100(n399);
        return g2e_pkg::LEAPS_W'(n3 >> 2) - g2e_pkg::LEAPS_W'(q99)
             + g2e_pkg::LEAPS_W'(q399 >> 2);
    endfunction

    assign base_eff = base_year_reg[YW-1:0];

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_year_reg <= g2e_pkg::BASE_YEAR_RST;
        end else if (cfg_we) begin
            base_year_reg <= cfg_wdata;
        end
    end

    // Input capture and validity check
    assign bad_next = (in_month < g2e_pkg::MONTH_FIRST) ||
                      (in_month > g2e_pkg::MONTH_LAST) || (in_day == '0);

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            year_reg   <= in_year[YW-1:0];
            month_reg  <= in_month;
            day_reg    <= in_day;
            hour_reg   <= in_hour;
            minute_reg <= in_minute;
            sec_us_reg <= in_second_us;
            bad_reg    <= bad_next;
        end
    end

    // Leap counts for both years and leap flag of the given year
    always_comb begin
        leaps_y_next = leaps_below(year_reg);
        leaps_b_next = leaps_below(base_eff);
        qy           = g2e_pkg::div100(SW'(year_reg));
        rem_y        = SW'(year_reg) - SW'(qy) * SW'(100);
        leap_next    = (year_reg[1:0] == 2'b00) &&
                       ((rem_y != '0) || (qy[1:0] == 2'b00));
    end

    always_ff @(posedge aclk) begin
        if (cmd.step_leap) begin
            leaps_y_reg <= leaps_y_next;
            leaps_b_reg <= leaps_b_next;
            leap_reg    <= leap_next;
        end
    end

    // Day count: whole years, days before month, day of month
    always_comb begin
        month_idx = month_reg - g2e_pkg::MONTH_FIRST;
        if (year_reg > base_eff) begin
            year_days = g2e_pkg::DAYS_W'(year_reg - base_eff) *
                        g2e_pkg::DAYS_W'(g2e_pkg::DAYS_PER_YEAR)
                      + g2e_pkg::DAYS_W'(leaps_y_reg) - g2e_pkg::DAYS_W'(leaps_b_reg);
        end else begin
            year_days = '0;
        end
        days_next = year_days
                  + g2e_pkg::DAYS_W'(g2e_pkg::days_before(leap_reg, month_idx))
                  + g2e_pkg::DAYS_W'(day_reg) - g2e_pkg::DAYS_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (cmd.step_days) begin
            days_reg <= days_next;
        end
    end

    // Minutes
    assign mins_next = g2e_pkg::MINS_W'(days_reg) * g2e_pkg::MINS_W'(g2e_pkg::MIN_PER_DAY)
                     + g2e_pkg::MINS_W'(hour_reg) * g2e_pkg::MINS_W'(g2e_pkg::MIN_PER_HOUR)
                     + g2e_pkg::MINS_W'(minute_reg);

    always_ff @(posedge aclk) begin
        if (cmd.step_min) begin
            mins_reg <= mins_next;
        end
    end

    // Minutes to microseconds, 32 x 26 product kept to the result width
    always_ff @(posedge aclk) begin
        if (cmd.step_us) begin
            prod_reg <= g2e_pkg::ELAPSED_W'(g2e_pkg::PROD_W'(mins_reg) *
                                            g2e_pkg::PROD_W'(g2e_pkg::US_PER_MIN));
        end
    end

    // Result register, zeroed for flagged requests
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            if (bad_reg) begin
                elapsed_reg <= '0;
                day_cnt_reg <= '0;
            end else begin
                elapsed_reg <= prod_reg + g2e_pkg::ELAPSED_W'(sec_us_reg);
                day_cnt_reg <= days_reg;
            end
            bad_out_reg <= bad_reg;
        end
    end

    assign out_elapsed_us = elapsed_reg;
    assign out_day_count  = day_cnt_reg;
    assign out_bad_input  = bad_out_reg;

endmodule

FILE: sv/gregorian_to_epoch_time_top.sv
// Gregorian date and time to elapsed microseconds and days since 1 January
// of a programmable base year. One request is taken while the block is idle
// and runs through five datapath steps (leap counts, day count, minutes,
// microsecond product, result load). m_tvalid rises as the result load moves
// the result into the output register, and the next request is accepted on
// the cycle after that; a new request is thus never taken before the last
// one has gone through all five steps. A result still held in the output
// register stalls the result load, and with it the next request, for as
// long as m_tready stays low. The sequence is set by the single shared
// datapath and its 32 x 26 bit product step. Month outside 1..12 or a zero
// day sets m_tuser and returns zero time and zero days. base_year resets
// to 1970. Depends on g2e_pkg, g2e_ctrl, g2e_dp.
module gregorian_to_epoch_time_top #(
    parameter int unsigned YEAR_WIDTH = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: base_year
    input  logic        cfg_we,
    input  logic [11:0] cfg_wdata,
    // Request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26],
    // second_us[57:32], zero fill[63:58]
    input  logic [63:0] s_tdata,
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // elapsed_us[56:0], day_count[77:57], zero fill[79:78]
    output logic [79:0] m_tdata,
    // bad_input[0]
    output logic        m_tuser
);

    g2e_pkg::cmd_t                   cmd;
    logic [g2e_pkg::ELAPSED_W-1:0]   elapsed_us;
    logic [g2e_pkg::DAYS_W-1:0]      day_count;

    g2e_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    g2e_dp #(
        .YEAR_WIDTH (YEAR_WIDTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_year        (s_tdata[11:0]),
        .in_month       (s_tdata[15:12]),
        .in_day         (s_tdata[20:16]),
        .in_hour        (s_tdata[25:21]),
        .in_minute      (s_tdata[31:26]),
        .in_second_us   (s_tdata[57:32]),
        .out_elapsed_us (elapsed_us),
        .out_day_count  (day_count),
        .out_bad_input  (m_tuser)
    );

    assign m_tdata = {2'b00, day_count, elapsed_us};

endmodule
